/* src/trd_pkg.sv */
// trd_pkg: shared types and constants for the tracker record deframer.
// No dependencies; imported by trd_drain, tracker_record_deframer, trd_checker and tb_top.
package trd_pkg;

  localparam int PAYLOAD_BYTES = 25;
  localparam int NUM_WORDS     = (PAYLOAD_BYTES - 1) / 2;
  localparam int MAX_RECEIVERS = 16;

  // word store: two banks of 16 slots, 12 used per bank
  localparam int RAM_DEPTH = 32;
  localparam int RAM_AW    = 5;
  localparam int WORD_W    = 16;

  localparam logic [4:0] IDX_BUTTON = 5'(PAYLOAD_BYTES - 1);
  localparam logic [4:0] IDX_ADDR   = 5'(PAYLOAD_BYTES);
  localparam logic [3:0] ELEM_LAST  = 4'(NUM_WORDS - 1);
  localparam logic [3:0] NUM_POS    = 4'd3;

  // full scale in 0.1 mm
  localparam logic [15:0] FS_36IN  = 16'd9144;
  localparam logic [15:0] FS_72IN  = 16'd18288;
  localparam logic [15:0] FS_144IN = 16'd36576;

  // configuration register indexes
  localparam logic [1:0] CFG_NUM_BIRDS      = 2'd0;
  localparam logic [1:0] CFG_NUM_RECEIVERS  = 2'd1;
  localparam logic [1:0] CFG_EXTENDED_RANGE = 2'd2;
  localparam logic [1:0] CFG_ERC_PRESENT    = 2'd3;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_CHECK = 2'd1,
    PH_BURST = 2'd2
  } phase_t;

  // record handed from the framer to the drain
  typedef struct packed {
    logic        valid;
    logic        bank;
    logic [3:0]  unit_address;
    logic [7:0]  buttons;
    logic [15:0] full_scale;
  } drn_launch_t;

  // per-result tag travelling down the drain pipeline
  typedef struct packed {
    logic [3:0]  unit_address;
    logic [3:0]  element;
    logic        is_pos;
    logic        last;
    logic [7:0]  buttons;
    logic [15:0] full_scale;
  } drn_meta_t;

endpackage

/* src/trd_ram.sv */
// trd_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module trd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/trd_drain.sv */
// trd_drain: reads the 12 words of a record from the word store, scales the
// position words and presents results. Depends on trd_pkg.
module trd_drain
  import trd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  drn_launch_t          launch,
  output logic                 busy,
  output logic                 rd_en,
  output logic [RAM_AW-1:0]    rd_addr,
  input  logic [WORD_W-1:0]    rd_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // unit_address[3:0], value[20:4], buttons[28:21]
  output logic [3:0]           out_tuser,  // element[3:0]
  output logic                 out_tlast
);

  // issue stage
  logic        active_r, active_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        bank_r;
  logic [3:0]  addr_r;
  logic [7:0]  btn_r;
  logic [15:0] fs_r;

  // pipeline: s1 = RAM data, s2 = product, then output register
  logic        s1_valid_r;
  drn_meta_t   s1_meta_r;
  logic        s2_valid_r;
  drn_meta_t   s2_meta_r;
  logic signed [32:0] s2_prod_r;
  logic [WORD_W-1:0]  s2_raw_r;
  logic        o_valid_r;
  drn_meta_t   o_meta_r;
  logic signed [16:0] o_value_r;

  logic               advance;
  drn_meta_t          issue_meta;
  logic signed [32:0] prod;
  logic signed [16:0] value_nxt;

  assign advance = !o_valid_r || out_tready;
  assign busy    = active_r;
  assign rd_en   = advance && active_r;
  assign rd_addr = {bank_r, idx_r};

  always_comb begin
    issue_meta.unit_address = addr_r;
    issue_meta.element      = idx_r;
    issue_meta.is_pos       = (idx_r < NUM_POS);
    issue_meta.last         = (idx_r == ELEM_LAST);
    issue_meta.buttons      = btn_r;
    issue_meta.full_scale   = fs_r;
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (launch.valid) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (rd_en) begin
      idx_nxt = idx_r + 4'd1;
      if (idx_r == ELEM_LAST) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (launch.valid) begin
      bank_r <= launch.bank;
      addr_r <= launch.unit_address;
      btn_r  <= launch.buttons;
      fs_r   <= launch.full_scale;
    end
  end

  assign prod = signed'(rd_data) * signed'({1'b0, s1_meta_r.full_scale});

  // floor(w * FS / 32768) is an arithmetic shift
  assign value_nxt = s2_meta_r.is_pos ? s2_prod_r[31:15]
                                      : 17'(signed'(s2_raw_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= rd_en;
      s2_valid_r <= s1_valid_r;
      o_valid_r  <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_meta_r <= issue_meta;
      s2_meta_r <= s1_meta_r;
      s2_prod_r <= prod;
      s2_raw_r  <= rd_data;
      o_meta_r  <= s2_meta_r;
      o_value_r <= value_nxt;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {3'b000, o_meta_r.buttons, o_value_r, o_meta_r.unit_address};
  assign out_tuser  = o_meta_r.element;
  assign out_tlast  = o_meta_r.last;

endmodule

/* src/tracker_record_deframer.sv */
// tracker_record_deframer: framer and word store of the tracker deframer.
// Depends on trd_pkg, trd_ram and trd_drain.
// Output: 12 results per record, each through the drain's s1, s2 and output
//   registers; one result a cycle while out_tready is high.
// Throughput: one byte a cycle; the address byte of a record waits while the
//   drain is still reading out the previous record.
// Reset: rst_n synchronous, active low; clears framer and drain control.
//   The word store is not cleared: every slot is written before it is read.
module tracker_record_deframer
  import trd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // unit_address[3:0], value[20:4], buttons[28:21]
  output logic [3:0]  out_tuser,   // element[3:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);

  // configuration
  logic [3:0] num_birds_r;
  logic [3:0] num_receivers_r;
  logic       extended_range_r;
  logic       erc_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_birds_r      <= 4'd1;
      num_receivers_r  <= 4'd1;
      extended_range_r <= 1'b0;
      erc_present_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_BIRDS:      num_birds_r      <= cfg_wdata;
        CFG_NUM_RECEIVERS:  num_receivers_r  <= cfg_wdata;
        CFG_EXTENDED_RANGE: extended_range_r <= cfg_wdata[0];
        CFG_ERC_PRESENT:    erc_present_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // framer state
  phase_t     phase_r, phase_nxt;
  logic [4:0] byte_idx_r, byte_idx_nxt;
  logic [3:0] recs_left_r, recs_left_nxt;
  logic [7:0] low_byte_r, low_byte_nxt;
  logic [7:0] btn_byte_r, btn_byte_nxt;
  logic       fill_bank_r, fill_bank_nxt;

  logic              accept;
  logic              in_record;
  logic              at_addr;
  logic              drn_busy;
  logic [7:0]        rx_byte;
  logic [7:0]        expect_addr;
  logic              addr_ok;
  logic [15:0]       full_scale;
  drn_launch_t       launch;

  logic              wr_en;
  logic [RAM_AW-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  assign rx_byte   = in_tdata;
  assign in_record = (phase_r == PH_CHECK) || (phase_r == PH_BURST);
  assign at_addr   = in_record && (byte_idx_r == IDX_ADDR);

  // the address byte hands a record to the drain, so it waits for a free drain
  assign in_tready = !(at_addr && drn_busy);
  assign accept    = in_tvalid && in_tready;

  // first receiver is address 1 when every unit has one, else 2
  assign expect_addr = (num_receivers_r == num_birds_r) ? 8'd1 : 8'd2;
  assign addr_ok     = ({1'b0, rx_byte} < 9'(MAX_RECEIVERS));

  always_comb begin
    if (erc_present_r) begin
      full_scale = FS_144IN;
    end else if (extended_range_r) begin
      full_scale = FS_72IN;
    end else begin
      full_scale = FS_36IN;
    end
  end

  // word = ((lo & 0x7F) | hi << 7) << 2, kept to 16 bits
  assign wr_data = {rx_byte[6:0], low_byte_r[6:0], 2'b00};
  assign wr_addr = {fill_bank_r, byte_idx_r[4:1]};
  assign wr_en   = accept && in_record && (byte_idx_r < IDX_BUTTON) && byte_idx_r[0];

  always_comb begin
    phase_nxt     = phase_r;
    byte_idx_nxt  = byte_idx_r;
    recs_left_nxt = recs_left_r;
    low_byte_nxt  = low_byte_r;
    btn_byte_nxt  = btn_byte_r;
    fill_bank_nxt = fill_bank_r;

    launch.valid        = 1'b0;
    launch.bank         = fill_bank_r;
    launch.unit_address = rx_byte[3:0];
    launch.buttons      = btn_byte_r;
    launch.full_scale   = full_scale;

    if (accept) begin
      case (phase_r)
        PH_CHECK, PH_BURST: begin
          if (byte_idx_r < IDX_BUTTON) begin
            if (!byte_idx_r[0]) begin
              low_byte_nxt = rx_byte;
            end
            byte_idx_nxt = byte_idx_r + 5'd1;
          end else if (byte_idx_r == IDX_BUTTON) begin
            btn_byte_nxt = rx_byte;
            byte_idx_nxt = byte_idx_r + 5'd1;
          end else if (phase_r == PH_CHECK && rx_byte != expect_addr) begin
            // wrong first receiver: start hunting again
            phase_nxt    = PH_HUNT;
            byte_idx_nxt = '0;
          end else begin
            if (phase_r == PH_CHECK) begin
              recs_left_nxt = (num_receivers_r > 4'd1) ? num_receivers_r - 4'd1 : 4'd0;
            end else if (recs_left_r != 4'd0) begin
              recs_left_nxt = recs_left_r - 4'd1;
            end
            // out-of-range address still counts in the burst but emits nothing
            if (addr_ok) begin
              launch.valid  = 1'b1;
              fill_bank_nxt = !fill_bank_r;
            end
            byte_idx_nxt = '0;
            phase_nxt    = (recs_left_nxt != 4'd0) ? PH_BURST : PH_HUNT;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (rx_byte[7]) begin
            low_byte_nxt = rx_byte;
            byte_idx_nxt = 5'd1;
            phase_nxt    = PH_CHECK;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      byte_idx_r  <= '0;
      recs_left_r <= '0;
      low_byte_r  <= '0;
      btn_byte_r  <= '0;
      fill_bank_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      byte_idx_r  <= byte_idx_nxt;
      recs_left_r <= recs_left_nxt;
      low_byte_r  <= low_byte_nxt;
      btn_byte_r  <= btn_byte_nxt;
      fill_bank_r <= fill_bank_nxt;
    end
  end

  // Two banks: the framer fills one while the drain reads the other, so a
  // write and a read never meet on one entry.
  trd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_words (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  trd_drain u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .launch     (launch),
    .busy       (drn_busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // checks
  a_no_bank_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr[RAM_AW-1] != rd_addr[RAM_AW-1]))
    else $error("word store read and write hit the same bank");

  a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    launch.valid |-> !drn_busy)
    else $error("record handed to a busy drain");

  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    launch.valid |=> drn_busy)
    else $error("drain did not start on a record");

  a_last_elem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == ELEM_LAST))
    else $error("record end flagged on the wrong element");

endmodule

/* sim/trd_checker.sv */
`timescale 1ns / 1ps
// trd_checker: monitors the byte, result and register ports of the tracker
// record deframer, predicts each result and compares it. Depends on trd_pkg.
module trd_checker
  import trd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte[7:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,   // unit_address[3:0], value[20:4], buttons[28:21]
  input  logic [3:0]  out_tuser,   // element[3:0]
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  output int          mismatches,
  output int          results_due
);

  typedef struct packed {
    logic [3:0]  unit_address;
    logic [3:0]  element;
    logic [16:0] value;
    logic [7:0]  buttons;
    logic        last;
  } tracker_result_t;

  // register mirror
  logic [3:0]  flock_size;
  logic [3:0]  receiver_count;
  logic        ext_range;
  logic        erc_fitted;

  // framer mirror
  phase_t      frame_phase;
  logic [4:0]  byte_pos;
  logic [3:0]  burst_left;
  logic [7:0]  low_half;
  logic [7:0]  button_latch;
  logic [15:0] word_store [NUM_WORDS];

  tracker_result_t pending_results [$];
  int              fault_count = 0;

  // floor(w * FS / 32768), FS in 0.1 mm
  function automatic logic [16:0] to_tenth_mm(input logic [15:0] w);
    longint full_scale;
    longint product;
    full_scale = erc_fitted ? longint'(FS_144IN) :
                 ext_range  ? longint'(FS_72IN)  : longint'(FS_36IN);
    product = longint'($signed(w)) * full_scale;
    return 17'(product >>> 15);
  endfunction

  task automatic queue_record(input logic [7:0] addr);
    tracker_result_t r;
    if (addr < MAX_RECEIVERS) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        r.unit_address = addr[3:0];
        r.element      = 4'(k);
        r.value        = (k < NUM_POS) ? to_tenth_mm(word_store[k])
                                       : {word_store[k][15], word_store[k]};
        r.buttons      = button_latch;
        r.last         = (4'(k) == ELEM_LAST);
        pending_results.push_back(r);
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [7:0] want;
    if (frame_phase != PH_CHECK && frame_phase != PH_BURST) begin
      // spare phase code behaves as hunting
      frame_phase = PH_HUNT;
      if (b[7]) begin
        low_half    = b;
        byte_pos    = 5'd1;
        frame_phase = PH_CHECK;
      end
    end else if (byte_pos < IDX_BUTTON) begin
      if (!byte_pos[0]) begin
        low_half = b;
      end else begin
        // high byte shifted past bit 15 is simply lost
        word_store[byte_pos[4:1]] = {b[6:0], low_half[6:0], 2'b00};
      end
      byte_pos++;
    end else if (byte_pos == IDX_BUTTON) begin
      button_latch = b;
      byte_pos++;
    end else begin
      want = (receiver_count == flock_size) ? 8'd1 : 8'd2;
      if (frame_phase == PH_CHECK && b != want) begin
        frame_phase = PH_HUNT;
        byte_pos    = '0;
      end else begin
        queue_record(b);
        if (frame_phase == PH_CHECK)
          burst_left = (receiver_count > 4'd1) ? receiver_count - 4'd1 : 4'd0;
        else if (burst_left != 0)
          burst_left--;
        byte_pos    = '0;
        frame_phase = (burst_left != 0) ? PH_BURST : PH_HUNT;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    tracker_result_t head;
    if (!rst_n) begin
      flock_size     = 4'd1;
      receiver_count = 4'd1;
      ext_range      = 1'b0;
      erc_fitted     = 1'b0;
      frame_phase    = PH_HUNT;
      byte_pos       = '0;
      burst_left     = '0;
      low_half       = '0;
      button_latch   = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_BIRDS:      flock_size     = cfg_wdata;
          CFG_NUM_RECEIVERS:  receiver_count = cfg_wdata;
          CFG_EXTENDED_RANGE: ext_range      = cfg_wdata[0];
          CFG_ERC_PRESENT:    erc_fitted     = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h tlast %b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          head = pending_results.pop_front();
          check_field("unit_address", 32'(head.unit_address), 32'(out_tdata[3:0]));
          check_field("value", 32'(head.value), 32'(out_tdata[20:4]));
          check_field("buttons", 32'(head.buttons), 32'(out_tdata[28:21]));
          check_field("tdata padding", 32'd0, 32'(out_tdata[31:29]));
          check_field("element", 32'(head.element), 32'(out_tuser));
          check_field("last", 32'(head.last), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready)
        take_byte(in_tdata);
    end
    mismatches  <= fault_count;
    results_due <= pending_results.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for tracker_record_deframer; the checker
// (trd_checker) sits beside the block. Depends on trd_pkg and both modules.
module tb_top
  import trd_pkg::*;
();

  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 32;    // covers the launch and the drain of one record
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off, fills the block
  localparam int STALL_LIMIT   = 3000;  // cycles with no request moving at all

  // opening bytes: two ignored bytes while hunting, then one record with
  // extreme words (largest positive, most negative, -4 for rounding towards
  // minus infinity, high bytes with bit 7 set), all buttons set, address 1
  localparam int OPENING_LEN = 28;
  localparam logic [7:0] OPENING [OPENING_LEN] = '{
    8'h00, 8'h7F,
    8'hFF, 8'h3F,  8'h00, 8'h40,  8'h7F, 8'h7F,  8'h7F, 8'h3F,
    8'h00, 8'h40,  8'h00, 8'h00,  8'hFF, 8'hFF,  8'h01, 8'h00,
    8'h80, 8'hC0,  8'h55, 8'h2A,  8'h2A, 8'h55,  8'h7F, 8'h7F,
    8'hFF, 8'h01
  };

  // register settings, one per phase. The long burst phase comes first, while
  // the framer is still hunting, and opens with a clean two-record burst under
  // the receiver hold-off. Receivers of 0 behaves as 1.
  localparam int NUM_SETTINGS = 6;
  localparam int LONG_BURST   = 0;
  localparam logic [3:0] SET_BIRDS     [NUM_SETTINGS] = '{4'd2, 4'd3, 4'd14, 4'd6, 4'd1, 4'd0};
  localparam logic [3:0] SET_RECEIVERS [NUM_SETTINGS] = '{4'd2, 4'd3, 4'd2,  4'd0, 4'd1, 4'd0};
  localparam logic       SET_EXT       [NUM_SETTINGS] = '{1'b1, 1'b0, 1'b0,  1'b1, 1'b1, 1'b0};
  localparam logic       SET_ERC       [NUM_SETTINGS] = '{1'b0, 1'b0, 1'b1,  1'b1, 1'b0, 1'b0};
  localparam int         SET_BUDGET    [NUM_SETTINGS] = '{0, 1, 1, 1, 1, 1};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RHYTHM} rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;     // rx_byte[7:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // unit_address[3:0], value[20:4], buttons[28:21]
  logic [3:0]  out_tuser;           // element[3:0]
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [3:0]  cfg_wdata  = '0;

  logic        hold_armed = 1'b0;
  int          mismatches;
  int          results_due;
  int          bytes_sent   = 0;
  int          run_left     = 0;
  int          quiet_cycles = 0;

  tracker_record_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  trd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One byte request. The sender runs in bursts of random length; between
  // bursts it drops tvalid for a random gap, which is often zero so that
  // long unbroken stretches occur too. tready is sampled at the edge itself,
  // before the block's registers move.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (run_left == 0) begin
      run_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    run_left--;
    bytes_sent++;
  endtask

  // random byte, biased towards the values that make extreme words
  function automatic logic [7:0] pick_half();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'hFF;
      3:       return 8'h40;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // 26-byte record: 12 lo/hi pairs, buttons, address. marked sets bit 7 of
  // the opening byte; full_high lets bit 7 through on the high bytes.
  task automatic send_record(input logic [7:0] addr, input bit marked, input bit full_high);
    logic [7:0] b;
    for (int k = 0; k < NUM_WORDS; k++) begin
      b = pick_half();
      if (k == 0)
        b[7] = marked;
      send_byte(b);
      b = pick_half();
      if (!full_high)
        b[7] = 1'b0;
      send_byte(b);
    end
    send_byte(8'($urandom_range(0, 255)));
    send_byte(addr);
  endtask

  // Mostly a well-formed burst: checked record with the expected first
  // address, then the rest of the burst with random addresses (some at or
  // above the receiver limit). The rest is line noise, a torn record or a
  // first record with the wrong address byte.
  task automatic send_burst(input logic [3:0] birds, input logic [3:0] receivers);
    logic [7:0] want;
    logic [7:0] addr;
    int         records;
    want = (birds == receivers) ? 8'd1 : 8'd2;
    if ($urandom_range(0, 7) == 0) begin
      send_byte(8'($urandom_range(128, 255)));
      repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 127)));
    end
    case ($urandom_range(0, 9))
      7:       addr = want ^ 8'h03;          // the other receiver address
      8:       addr = want | 8'h10;          // right low nibble, wrong upper bits
      9:       addr = 8'($urandom_range(0, 255));
      default: addr = want;
    endcase
    send_record(addr, 1'b1, $urandom_range(0, 3) == 0);
    if (addr == want) begin
      records = (receivers == 0) ? 1 : int'(receivers);
      for (int r = 1; r < records; r++) begin
        case ($urandom_range(0, 7))
          6:       addr = 8'(MAX_RECEIVERS);
          7:       addr = 8'($urandom_range(MAX_RECEIVERS + 1, 255));
          default: addr = 8'($urandom_range(0, MAX_RECEIVERS - 1));
        endcase
        send_record(addr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // sender stops until every expected result is out, then waits for the
  // block to finish any record that produces nothing
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int quota;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one receiver, one bird, 36 inch scale
    foreach (OPENING[i]) send_byte(OPENING[i]);
    settle();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      // single-bit registers get junk in the unused upper bits
      write_reg(CFG_NUM_BIRDS, SET_BIRDS[p]);
      write_reg(CFG_NUM_RECEIVERS, SET_RECEIVERS[p]);
      write_reg(CFG_EXTENDED_RANGE, {3'($urandom_range(0, 7)), SET_EXT[p]});
      write_reg(CFG_ERC_PRESENT, {3'($urandom_range(0, 7)), SET_ERC[p]});
      cfg_we <= 1'b0;
      if (p == LONG_BURST) begin
        // birds equal receivers here, so the first receiver is address 1;
        // the second address byte waits behind the held results
        hold_armed <= 1'b1;
        send_record(8'd1, 1'b1, 1'b0);
        send_record(8'($urandom_range(0, MAX_RECEIVERS - 1)), 1'b0, 1'b1);
      end
      quota = bytes_sent + SET_BUDGET[p];
      while (bytes_sent < quota)
        send_burst(SET_BIRDS[p], SET_RECEIVERS[p]);
      settle();
    end

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Receiver: spans of always-ready, coin-toss, or a fixed two-in-three
  // rhythm. Once armed it holds off for a long stretch so that results back
  // up, the address byte of the next record waits and byte requests stall.
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    int       beat;
    bit       held;
    held = 1'b0;
    beat = 0;
    forever begin
      if (hold_armed && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(4, 48);
      repeat (span) begin
        if (hold_armed && !held)
          break;
        case (mode)
          RX_OPEN: out_tready <= 1'b1;
          RX_COIN: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= (beat % 3 != 0);
        endcase
        beat++;
        @(posedge clk);
      end
    end
  end

  // watchdog: any request on any port restarts the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
